// File: rtl/core/ssvf_pkg.sv
`default_nettype none
package ssvf_pkg;
  localparam int NLANE = 4;

  localparam logic [1:0] MODE_LOW  = 2'd0;
  localparam logic [1:0] MODE_BAND = 2'd1;

  localparam logic [2:0] CFG_FREQ  = 3'd0;
  localparam logic [2:0] CFG_DAMP  = 3'd1;
  localparam logic [2:0] CFG_CLIP  = 3'd2;
  localparam logic [2:0] CFG_GAIN  = 3'd3;
  localparam logic [2:0] CFG_MODE  = 3'd4;
  localparam logic [2:0] CFG_POLE  = 3'd5;

  localparam logic [17:0] DAMP_FLOOR = 18'd6554;
  localparam logic [17:0] DAMP_ONE   = 18'd65536;

  typedef struct packed {
    logic [17:0] freq;
    logic [17:0] damp;
    logic [16:0] clip;
    logic [16:0] gain;
    logic [1:0]  mode;
  } cfg_t;

  // saturate a 34 bit sum to 32 bits
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // coefficient times state, rounded, floor shift, saturated
  function automatic logic signed [31:0] cmul(input logic [17:0] c,
                                              input logic signed [31:0] v);
    logic signed [50:0] p;
    logic signed [34:0] s;
    p = $signed({1'b0, c}) * v + 51'sd32768;
    s = p[50:16];
    if (s > 35'sd2147483647) return 32'sh7fffffff;
    if (s < -35'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  function automatic logic [23:0] to_sample(input logic signed [31:0] v);
    logic signed [32:0] s;
    logic signed [28:0] o;
    s = {v[31], v} + 33'sd8;
    o = s[32:4];
    if (o > 29'sd8388607) return 24'h7fffff;
    if (o < -29'sd8388608) return 24'h800000;
    return o[23:0];
  endfunction
endpackage
`default_nettype wire

// File: rtl/core/ssvf_lane.sv
`default_nettype none
// One filter lane: sequences its recurrence over a shared multiplier, one
// product per cycle. start loads x; done pulses with the gained output.
module ssvf_lane (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] x,
  input  wire ssvf_pkg::cfg_t     cfg,
  output logic                    done,
  output logic signed [31:0]      y
);
  typedef enum logic [3:0] {
    S_IDLE, S_L1, S_H1A, S_H1B, S_B1, S_L2, S_H2A, S_H2B, S_B2,
    S_SQ, S_P, S_BS, S_LS, S_OUT
  } st_t;

  st_t st_r;
  logic signed [31:0] band_r, low_r, x_r, l_r, h_r, b_r, t_r, y_r;
  logic [17:0] df_r;
  logic [38:0] sq_r;
  logic done_r;

  logic signed [31:0] m;
  logic [17:0] mc;
  logic signed [31:0] mv;
  logic signed [63:0] sqp;
  logic [56:0] pp;
  logic [40:0] pw;
  logic signed [31:0] tap;

  always_comb begin
    tap = (cfg.mode == ssvf_pkg::MODE_LOW) ? l_r :
          (cfg.mode == ssvf_pkg::MODE_BAND) ? b_r : h_r;
    mc = cfg.freq;
    mv = band_r;
    unique case (st_r)
      S_L1:   begin mc = cfg.freq; mv = band_r; end
      S_H1A:  begin mc = cfg.damp; mv = band_r; end
      S_H1B:  begin mc = cfg.freq; mv = h_r; end
      S_B1:   begin mc = cfg.freq; mv = b_r; end
      S_L2:   begin mc = cfg.damp; mv = b_r; end
      S_H2A:  begin mc = cfg.freq; mv = h_r; end
      S_BS:   begin mc = df_r; mv = b_r; end
      S_LS:   begin mc = df_r; mv = l_r; end
      S_OUT:  begin mc = {1'b0, cfg.gain}; mv = tap; end
      default: begin mc = cfg.freq; mv = band_r; end
    endcase
    m = ssvf_pkg::cmul(mc, mv);
    sqp = b_r * b_r;
    pp = {40'd0, cfg.clip} * {18'd0, sq_r};
    pw = pp[56:16] + 41'(pp[15]);
  end

  // sequencer: L1 H1 B1 L2 H2 B2, damping, gain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; done_r <= 1'b0;
      band_r <= '0; low_r <= '0; df_r <= '0;
    end else begin
      done_r <= (st_r == S_OUT);
      unique case (st_r)
        S_IDLE: if (start) begin x_r <= x; st_r <= S_L1; end
        S_L1:  begin l_r <= ssvf_pkg::sat34(34'(low_r) + 34'(m)); st_r <= S_H1A; end
        S_H1A: begin
          h_r <= ssvf_pkg::sat34(34'(x_r) - 34'(l_r) - 34'(m)); st_r <= S_H1B;
        end
        S_H1B: begin b_r <= ssvf_pkg::sat34(34'(band_r) + 34'(m)); st_r <= S_B1; end
        S_B1:  begin l_r <= ssvf_pkg::sat34(34'(l_r) + 34'(m)); st_r <= S_L2; end
        S_L2:  begin
          h_r <= ssvf_pkg::sat34(34'(x_r) - 34'(l_r) - 34'(m)); st_r <= S_H2A;
        end
        S_H2A: begin b_r <= ssvf_pkg::sat34(34'(b_r) + 34'(m)); st_r <= S_SQ; end
        S_H2B: st_r <= S_SQ;
        S_B2:  st_r <= S_SQ;
        S_SQ:  begin
          sq_r <= 39'((64'(sqp) + (64'd1 << 37)) >> 38); st_r <= S_P;
        end
        S_P:   begin
          df_r <= df_r;
          st_r <= S_BS;
        end
        S_BS:  begin band_r <= m; st_r <= S_LS; end
        S_LS:  begin
          low_r <= m;
          df_r <= (pw >= 41'(ssvf_pkg::DAMP_ONE - ssvf_pkg::DAMP_FLOOR)) ?
                  ssvf_pkg::DAMP_FLOOR : 18'(41'(ssvf_pkg::DAMP_ONE) - pw);
          st_r <= S_OUT;
        end
        S_OUT: begin y_r <= m; st_r <= S_IDLE; end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign y = y_r;
endmodule
`default_nettype wire

// File: rtl/core/saturating_state_variable_filter.sv
`default_nettype none
// Each input item is taken only while idle and runs each lane's 11-step
// one-product-per-cycle sequence twice (two sub-steps); the next item
// is accepted once the second result has moved to the output register;
// a result held by the receiver delays the next sub-step.
// Four lanes run side by side; the output stage merges the lane results.
// Synchronous active-low reset clears control and configuration registers, filter state and damping.
module saturating_state_variable_filter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // left_in[23:0], right_in[47:24]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // left_out[23:0], right_out[47:24]
  output logic             out_tlast,  // last_of_pair
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [17:0] cfg_wdata
);
  ssvf_pkg::cfg_t cfg_r;
  logic pole_r;
  logic busy_r, sub_r, run_r, ov_r, olast_r, pend_r;
  logic [47:0] od_r;
  logic signed [31:0] xl_r, xr_r, s1l_r, s1r_r;
  logic signed [31:0] lx [ssvf_pkg::NLANE];
  logic signed [31:0] ly [ssvf_pkg::NLANE];
  logic [ssvf_pkg::NLANE-1:0] ldone;
  logic res_load;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0; pole_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ssvf_pkg::CFG_FREQ: cfg_r.freq <= cfg_wdata;
        ssvf_pkg::CFG_DAMP: cfg_r.damp <= cfg_wdata;
        ssvf_pkg::CFG_CLIP: cfg_r.clip <= cfg_wdata[16:0];
        ssvf_pkg::CFG_GAIN: cfg_r.gain <= cfg_wdata[16:0];
        ssvf_pkg::CFG_MODE: cfg_r.mode <= cfg_wdata[1:0];
        ssvf_pkg::CFG_POLE: pole_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign lx[0] = xl_r;
  assign lx[1] = xr_r;
  assign lx[2] = pole_r ? s1l_r : 32'sd0;
  assign lx[3] = pole_r ? s1r_r : 32'sd0;

  for (genvar i = 0; i < ssvf_pkg::NLANE; i++) begin : g_lane
    ssvf_lane u_lane (.clk, .rst_n, .start(run_r), .x(lx[i]), .cfg(cfg_r),
                      .done(ldone[i]), .y(ly[i]));
  end

  assign in_tready = !busy_r;

  // lane results move to the output register once it is free
  assign res_load = busy_r && (pend_r || ldone[0]) && (!ov_r || out_tready);

  // sub-step control and result merge; pend_r holds a finished sub-step
  // while the previous result is still waiting
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; sub_r <= 1'b0; run_r <= 1'b0; ov_r <= 1'b0;
      pend_r <= 1'b0;
      s1l_r <= '0; s1r_r <= '0;
    end else begin
      run_r <= (in_tvalid && !busy_r) || (res_load && !sub_r);
      pend_r <= (pend_r || ldone[0]) && !res_load;
      if (res_load) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
      if (in_tvalid && !busy_r) begin
        busy_r <= 1'b1; sub_r <= 1'b0;
        xl_r <= {{4{in_tdata[23]}}, in_tdata[23:0], 4'd0};
        xr_r <= {{4{in_tdata[47]}}, in_tdata[47:24], 4'd0};
      end else if (res_load) begin
        s1l_r <= ly[0]; s1r_r <= ly[1];
        od_r <= {ssvf_pkg::to_sample(pole_r ? ly[3] : ly[1]),
                 ssvf_pkg::to_sample(pole_r ? ly[2] : ly[0])};
        olast_r <= sub_r;
        if (sub_r) busy_r <= 1'b0;
        else sub_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
  assign out_tlast = olast_r;

  a_lanes_sync: assert property (@(posedge clk) disable iff (!rst_n)
    ldone[0] |-> (&ldone)) else $error("lanes out of step");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_tready) else $error("accept while busy");
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> busy_r) else $error("lane start while idle");
endmodule
`default_nettype wire
